// ----- rtl/bam3_pkg.sv -----
// Shared constants, types and helper functions for the border-aware 3x3 box mean unit
// No dependencies; imported by border_aware_box_mean_3x3_unit and the testbench
`default_nettype none

package bam3_pkg;

   // frame geometry and pixel format
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int DIM_BITS = 11;

   // register file
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_MODE  = 2'd2;

   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_ALL  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_EVEN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ODD  = 2'd2;

   // neighbourhood arithmetic: nine pixels at most
   localparam int CNT_BITS   = 4;
   localparam int SUM_BITS   = PIXEL_BITS + CNT_BITS;
   localparam int RECIP_SH   = 16;
   localparam int RECIP_BITS = RECIP_SH + 1;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

   localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] HGT_MAX = DIM_BITS'(MAX_HEIGHT);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] mean;
      logic [CNT_BITS-1:0]   used;
      logic                  frame_end;
      logic                  run_last;
   } res_type;

   // ceil(2^16 / d): exact floor division for sums up to nine full-scale pixels
   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] d);
      logic [RECIP_BITS-1:0] r;
      case (d)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

   // parity filter on one neighbour
   function automatic logic counts(input logic [PIXEL_BITS-1:0] v,
                                   input logic [MODE_BITS-1:0] mode);
      logic ok;
      case (mode)
         MODE_EVEN: ok = ~v[0];
         MODE_ODD:  ok = v[0];
         default:   ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage : bam3_pkg

`default_nettype wire

// ----- rtl/border_aware_box_mean_3x3_unit.sv -----
// Border-aware 3x3 box mean over a raster pixel stream, two line memories inside
// Depends on bam3_pkg (geometry constants, reciprocal table, parity filter)
// Timing: an accepted item steps through S_READ, S_SUM and S_DIV, set by the line memory
// read, the neighbourhood adder and the reciprocal multiply, before its 0..2 results are
// offered; the input stalls until they have all been taken; an ignored drain is taken
// without entering the sequencer.
// Reset (synchronous): position, window and result count cleared, size registers set to the
// maximum and mode to MODE_ALL; line memories are not cleared, each entry is written before it can reach a result.
`default_nettype none

module border_aware_box_mean_3x3_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   // input channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [bam3_pkg::PIXEL_BITS-1:0]     req_pixel,
   input  wire                                 req_drain,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [bam3_pkg::PIXEL_BITS-1:0]     rsp_mean,
   output logic [bam3_pkg::CNT_BITS-1:0]       rsp_neighbours_used,
   output logic                                rsp_frame_end,
   output logic                                rsp_run_last,
   // configuration write channel
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [bam3_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [bam3_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bam3_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;
   localparam logic [1:0] S_DIV  = 2'd3;

   // control and configuration
   logic [1:0]            state_ff, state_in;
   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [MODE_BITS-1:0]  mode_ff;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;

   // per-item context captured at the input transfer
   logic [COL_BITS-1:0]   addr_ff;
   logic [PIXEL_BITS-1:0] px_ff;
   logic                  in_frame_ff, top_ok_ff, has_a_ff, has_b_ff;
   logic                  left_a_ff, left_b_ff;

   // line memories and their registered read data
   logic [PIXEL_BITS-1:0] line_above_ff     [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] line_two_above_ff [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] above_rd_ff, two_above_rd_ff;

   // shift window, rows two-above / above / current
   logic [PIXEL_BITS-1:0] window_ff [9];
   logic [PIXEL_BITS-1:0] window_in [9];

   // neighbourhood sums
   logic [SUM_BITS-1:0]   sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [CNT_BITS-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;

   // result buffer
   res_type               res_ff [2];
   logic [1:0]            out_cnt_ff;
   logic                  head_ff;

   logic [DIM_BITS-1:0]   eff_w, eff_h;
   logic [ROW_BITS-1:0]   r_eff;
   logic [COL_BITS-1:0]   c_eff;
   logic                  in_frame, req_xfer, rsp_xfer, csr_xfer, item_go;
   logic                  size_write;
   logic [DIM_BITS-1:0]   c_next;
   logic [PROD_BITS-1:0]  prod_a, prod_b;
   res_type               res_a, res_b;

   // effective geometry and clamped position
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_BITS'(1);
      end else if (width_ff > DIM_MAX) begin
         eff_w = DIM_MAX;
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = DIM_BITS'(1);
      end else if (height_ff > HGT_MAX) begin
         eff_h = HGT_MAX;
      end else begin
         eff_h = height_ff;
      end
      r_eff = (DIM_BITS'(row_ff) > eff_h) ? ROW_BITS'(eff_h) : row_ff;
      c_eff = (DIM_BITS'(col_ff) >= eff_w) ? COL_BITS'(eff_w - DIM_BITS'(1)) : col_ff;
      in_frame = DIM_BITS'(r_eff) < eff_h;
   end

   // handshakes; a pending register write holds off the input
   assign req_stall = (state_ff != S_IDLE) || (out_cnt_ff != 2'd0) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE) && (out_cnt_ff == 2'd0);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_xfer  = csr_valid && csr_ready;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   // a drain inside the frame is dropped without touching the state
   assign item_go   = req_xfer && !(req_drain && in_frame);
   assign size_write = csr_xfer
                       && ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   // position advance; a size write restarts the frame
   always_comb begin
      c_next = DIM_BITS'(c_eff) + DIM_BITS'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (size_write) begin
         col_in = '0;
         row_in = '0;
      end else if (item_go) begin
         if (c_next >= eff_w) begin
            col_in = '0;
            row_in = in_frame ? (r_eff + ROW_BITS'(1)) : '0;
         end else begin
            col_in = COL_BITS'(c_next);
            row_in = r_eff;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (item_go) state_in = S_READ;
         end
         S_READ:  state_in = S_SUM;
         S_SUM:   state_in = S_DIV;
         S_DIV:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         width_ff  <= DIM_MAX;
         height_ff <= HGT_MAX;
         mode_ff   <= MODE_ALL;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (csr_xfer) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: height_ff <= csr_data;
               CSR_FILTER_MODE:  mode_ff   <= csr_data[MODE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // item context at the input transfer
   always_ff @(posedge clock) begin
      if (item_go) begin
         addr_ff     <= c_eff;
         px_ff       <= in_frame ? req_pixel : '0;
         in_frame_ff <= in_frame;
         top_ok_ff   <= r_eff >= ROW_BITS'(2);
         has_a_ff    <= (r_eff >= ROW_BITS'(1)) && (c_eff >= COL_BITS'(1));
         has_b_ff    <= (r_eff >= ROW_BITS'(1))
                        && (DIM_BITS'(c_eff) == (eff_w - DIM_BITS'(1)));
         left_a_ff   <= c_eff >= COL_BITS'(2);
         left_b_ff   <= c_eff >= COL_BITS'(1);
      end
   end

   // line memory read, issued with the transfer
   always_ff @(posedge clock) begin
      if (item_go) begin
         above_rd_ff     <= line_above_ff[c_eff];
         two_above_rd_ff <= line_two_above_ff[c_eff];
      end
   end

   // line memory write-back in S_READ, the cycle after the transfer
   always_ff @(posedge clock) begin
      if ((state_ff == S_READ) && in_frame_ff) begin
         line_above_ff[addr_ff]     <= px_ff;
         line_two_above_ff[addr_ff] <= above_rd_ff;
      end
   end

   // window shift
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         window_in[k*3+0] = window_ff[k*3+1];
         window_in[k*3+1] = window_ff[k*3+2];
      end
      window_in[2] = two_above_rd_ff;
      window_in[5] = above_rd_ff;
      window_in[8] = px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) window_ff[i] <= '0;
      end else if (state_ff == S_READ) begin
         for (int i = 0; i < 9; i++) window_ff[i] <= window_in[i];
      end
   end

   // masked sums for the two possible results
   always_comb begin
      logic row_ok;
      logic ok_a, ok_b;
      sum_a_in = '0;
      cnt_a_in = '0;
      sum_b_in = '0;
      cnt_b_in = '0;
      for (int i = 0; i < 9; i++) begin
         row_ok = ((i / 3) == 1) || (((i / 3) == 0) && top_ok_ff)
                  || (((i / 3) == 2) && in_frame_ff);
         ok_a = row_ok && (((i % 3) != 0) || left_a_ff)
                && counts(window_ff[i], mode_ff);
         ok_b = row_ok && (((i % 3) == 2) || (((i % 3) == 1) && left_b_ff))
                && counts(window_ff[i], mode_ff);
         if (ok_a) begin
            sum_a_in = sum_a_in + SUM_BITS'(window_ff[i]);
            cnt_a_in = cnt_a_in + CNT_BITS'(1);
         end
         if (ok_b) begin
            sum_b_in = sum_b_in + SUM_BITS'(window_ff[i]);
            cnt_b_in = cnt_b_in + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         sum_a_ff <= sum_a_in;
         cnt_a_ff <= cnt_a_in;
         sum_b_ff <= sum_b_in;
         cnt_b_ff <= cnt_b_in;
      end
   end

   // division by the neighbour count through the reciprocal table
   always_comb begin
      prod_a = PROD_BITS'(sum_a_ff) * PROD_BITS'(recip(cnt_a_ff));
      prod_b = PROD_BITS'(sum_b_ff) * PROD_BITS'(recip(cnt_b_ff));
      res_a.mean      = prod_a[RECIP_SH +: PIXEL_BITS];
      res_a.used      = cnt_a_ff;
      res_a.frame_end = 1'b0;
      res_a.run_last  = !has_b_ff;
      res_b.mean      = prod_b[RECIP_SH +: PIXEL_BITS];
      res_b.used      = cnt_b_ff;
      res_b.frame_end = !in_frame_ff;
      res_b.run_last  = 1'b1;
   end

   // result buffer, two entries drained in order
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV) begin
         res_ff[0] <= has_a_ff ? res_a : res_b;
         res_ff[1] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
         head_ff    <= 1'b0;
      end else if (state_ff == S_DIV) begin
         out_cnt_ff <= 2'(has_a_ff) + 2'(has_b_ff);
         head_ff    <= 1'b0;
      end else if (rsp_xfer) begin
         out_cnt_ff <= out_cnt_ff - 2'd1;
         head_ff    <= 1'b1;
      end
   end

   assign rsp_valid           = out_cnt_ff != 2'd0;
   assign rsp_mean            = res_ff[head_ff].mean;
   assign rsp_neighbours_used = res_ff[head_ff].used;
   assign rsp_frame_end       = res_ff[head_ff].frame_end;
   assign rsp_run_last        = res_ff[head_ff].run_last;

   // checks
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE))
      else $error("result offered while an item is still in work");

   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_run_last)
      else $error("frame end not on the last result of its item");

   a_empty_mean_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_neighbours_used == '0)) |-> (rsp_mean == '0))
      else $error("nonzero mean with no neighbours");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (DIM_BITS'(col_ff) < eff_w) || $past(csr_xfer))
      else $error("column position beyond frame width");

   a_fill_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_DIV))
      else $error("result buffer filled outside the divide step");

   a_xfer_starts_read: assert property (@(posedge clock) disable iff (reset)
      item_go |=> (state_ff == S_READ))
      else $error("accepted item did not start a memory read");

endmodule : border_aware_box_mean_3x3_unit

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for border_aware_box_mean_3x3_unit: raster frames in, box means out
// Depends on bam3_pkg and the unit; a scoreboard class predicts every mean on input transfer
`default_nettype none

module testbench;
   import bam3_pkg::*;

   // neighbourhood predictor and the queue of means still due
   class box_mean_tracker;
      bit [PIXEL_BITS-1:0] line_above [MAX_WIDTH];
      bit [PIXEL_BITS-1:0] line_two_above [MAX_WIDTH];
      bit [PIXEL_BITS-1:0] win [9];
      int unsigned col_pos;
      int unsigned row_pos;
      bit [DIM_BITS-1:0] width_reg;
      bit [DIM_BITS-1:0] height_reg;
      bit [MODE_BITS-1:0] mode_reg;
      res_type due_means[$];
      int unsigned mean_faults;

      function new();
         width_reg   = DIM_BITS'(MAX_WIDTH);
         height_reg  = DIM_BITS'(MAX_HEIGHT);
         mode_reg    = MODE_ALL;
         col_pos     = 0;
         row_pos     = 0;
         mean_faults = 0;
      endfunction

      // 0 acts as 1, anything above the limit as the limit
      function int unsigned span(bit [DIM_BITS-1:0] v, int unsigned lim);
         if (v == 0) return 1;
         if (v > lim) return lim;
         return v;
      endfunction

      function void write_reg(bit [CSR_IDX_BITS-1:0] idx, bit [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH: begin
               width_reg = data;
               col_pos   = 0;
               row_pos   = 0;
            end
            CSR_FRAME_HEIGHT: begin
               height_reg = data;
               col_pos    = 0;
               row_pos    = 0;
            end
            CSR_FILTER_MODE: begin
               mode_reg = data[MODE_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // parity selection of one neighbour
      function bit admits(bit [PIXEL_BITS-1:0] v);
         case (mode_reg)
            MODE_EVEN: return !v[0];
            MODE_ODD:  return v[0];
            default:   return 1'b1;
         endcase
      endfunction

      // mean over window columns ctr-1..ctr+1, masked at the frame border
      function res_type box_mean(int ctr, bit left_ok, bit right_ok, bit top_ok, bit bot_ok);
         int unsigned total;
         int unsigned n;
         int col;
         bit [PIXEL_BITS-1:0] v;
         res_type r;
         total = 0;
         n = 0;
         for (int rr = 0; rr < 3; rr++) begin
            if (rr == 0 && !top_ok) continue;
            if (rr == 2 && !bot_ok) continue;
            for (int dc = -1; dc <= 1; dc++) begin
               col = ctr + dc;
               if (dc < 0 && !left_ok) continue;
               if (dc > 0 && !right_ok) continue;
               if (col < 0 || col > 2) continue;
               v = win[rr*3 + col];
               if (admits(v)) begin
                  total += v;
                  n++;
               end
            end
         end
         r.mean      = (n != 0) ? PIXEL_BITS'(total / n) : '0;
         r.used      = CNT_BITS'(n);
         r.frame_end = 1'b0;
         r.run_last  = 1'b0;
         return r;
      endfunction

      // one input transfer: shift the window, update the lines, queue 0..2 means
      function void accept_pixel(bit [PIXEL_BITS-1:0] pixel, bit drain);
         int unsigned w;
         int unsigned h;
         int unsigned r;
         int unsigned c;
         int n;
         bit in_frame;
         bit [PIXEL_BITS-1:0] px;
         bit [PIXEL_BITS-1:0] top;
         bit [PIXEL_BITS-1:0] mid;
         res_type got [2];
         w = span(width_reg, MAX_WIDTH);
         h = span(height_reg, MAX_HEIGHT);
         r = row_pos;
         c = col_pos;
         n = 0;
         if (r > h) r = h;
         if (c >= w) c = w - 1;
         in_frame = (r < h);
         // drain while still inside the frame is ignored
         if (drain && in_frame) return;
         px  = in_frame ? pixel : '0;
         top = line_two_above[c];
         mid = line_above[c];
         for (int k = 0; k < 3; k++) begin
            win[k*3]     = win[k*3 + 1];
            win[k*3 + 1] = win[k*3 + 2];
         end
         win[2] = top;
         win[5] = mid;
         win[8] = px;
         if (in_frame) begin
            line_two_above[c] = mid;
            line_above[c]     = px;
         end
         if (r >= 1) begin
            if (c >= 1) begin
               got[n] = box_mean(1, c >= 2, 1'b1, r >= 2, in_frame);
               n++;
            end
            if (c == w - 1) begin
               got[n] = box_mean(2, c >= 1, 1'b0, r >= 2, in_frame);
               got[n].frame_end = !in_frame;
               n++;
            end
            if (n > 0) got[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++) due_means.insert(due_means.size(), got[i]);
         end
         c++;
         if (c >= w) begin
            c = 0;
            r = in_frame ? r + 1 : 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      // compare one result transfer with the oldest due mean
      function void check_mean(logic [PIXEL_BITS-1:0] mean, logic [CNT_BITS-1:0] used,
                               logic frame_end, logic run_last);
         res_type want;
         if (due_means.size() == 0) begin
            if (mean_faults < 10)
               $display("unexpected result: mean %0d used %0d frame_end %0b run_last %0b",
                        mean, used, frame_end, run_last);
            mean_faults++;
            return;
         end
         want = due_means.pop_front();
         if (mean !== want.mean || used !== want.used ||
             frame_end !== want.frame_end || run_last !== want.run_last) begin
            if (mean_faults < 10)
               $display("mismatch: expected mean %0d used %0d frame_end %0b run_last %0b, %s",
                        want.mean, want.used, want.frame_end, want.run_last,
                        $sformatf("got mean %0d used %0d frame_end %0b run_last %0b",
                                  mean, used, frame_end, run_last));
            mean_faults++;
         end
      endfunction

      function void close_out();
         if (due_means.size() != 0) begin
            $display("results never arrived: %0d", due_means.size());
            mean_faults += due_means.size();
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [PIXEL_BITS-1:0] req_pixel = '0;
   logic req_drain = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   wire req_stall;
   wire rsp_valid;
   wire [PIXEL_BITS-1:0] rsp_mean;
   wire [CNT_BITS-1:0] rsp_neighbours_used;
   wire rsp_frame_end;
   wire rsp_run_last;
   wire csr_ready;

   box_mean_tracker tracker = new();

   bit sender_gaps = 1'b0;
   bit receiver_gaps = 1'b0;
   bit hold_request = 1'b0;
   int unsigned items_sent = 0;

   border_aware_box_mean_3x3_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .req_drain           (req_drain),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mean            (rsp_mean),
      .rsp_neighbours_used (rsp_neighbours_used),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_run_last        (rsp_run_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // give up after a generous bound
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: check each transfer, then choose the next stall
   initial begin
      int unsigned burst;
      int unsigned hold_left;
      burst = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_mean(rsp_mean, rsp_neighbours_used, rsp_frame_end, rsp_run_last);
         if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // one input transfer, optionally followed by a gap
   task automatic send_item(input bit [PIXEL_BITS-1:0] p, input bit d);
      req_pixel <= p;
      req_drain <= d;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_pixel(p, d);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // register write transfer, valid dropped afterwards
   task automatic write_csr(input bit [CSR_IDX_BITS-1:0] idx,
                            input bit [CSR_DATA_BITS-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every due mean has come out, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.due_means.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic bit [PIXEL_BITS-1:0] pick_pixel(int unsigned palette);
      case (palette)
         1: return ($urandom_range(0, 1) == 0) ? PIXEL_BITS'($urandom_range(0, 1))
                                               : PIXEL_BITS'($urandom_range(254, 255));
         2: return PIXEL_BITS'($urandom_range(0, 127) * 2);
         3: return PIXEL_BITS'($urandom_range(0, 127) * 2 + 1);
         default: return PIXEL_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // one frame plus its flush row, with stray drains and stray pixels; cut stops it early
   task automatic send_frame(input int unsigned w, input int unsigned h,
                             input int unsigned palette, input int unsigned cut);
      int unsigned sent;
      sent = 0;
      for (int unsigned r = 0; r <= h; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if (cut != 0 && sent >= cut) return;
            if (r < h) begin
               if ($urandom_range(0, 15) == 0) send_item(pick_pixel(palette), 1'b1);
               send_item(pick_pixel(palette), 1'b0);
            end else if ($urandom_range(0, 7) == 0) begin
               send_item(pick_pixel(palette), 1'b0);
            end else begin
               send_item(PIXEL_BITS'($urandom_range(0, 255)), 1'b1);
            end
            sent++;
            items_sent++;
         end
      end
   endtask

   function automatic int unsigned eff_size(bit [DIM_BITS-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   // stimulus
   initial begin
      int unsigned random_base;
      bit [DIM_BITS-1:0] w_val;
      bit [DIM_BITS-1:0] h_val;
      int unsigned w;
      int unsigned h;
      int unsigned frames;
      int unsigned cut;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-scale 3x3 frame: corners, edges, centre at maximum sum
      write_csr(CSR_FRAME_WIDTH, 11'd3);
      write_csr(CSR_FRAME_HEIGHT, 11'd3);
      write_csr(CSR_FILTER_MODE, CSR_DATA_BITS'(MODE_ALL));
      repeat (3) send_item(8'd255, 1'b0);
      send_item(8'd17, 1'b1);
      repeat (6) send_item(8'd255, 1'b0);
      send_item(8'd0, 1'b1);
      send_item(8'd123, 1'b0);
      send_item(8'd255, 1'b1);
      settle();

      // odd-only over all-zero pixels: nothing counted
      write_csr(CSR_FILTER_MODE, CSR_DATA_BITS'(MODE_ODD));
      write_csr(CSR_FRAME_WIDTH, 11'd2);
      write_csr(CSR_FRAME_HEIGHT, 11'd2);
      repeat (4) send_item(8'd0, 1'b0);
      repeat (2) send_item(8'd0, 1'b1);
      settle();

      // single pixel frame, unused register index, even-only
      write_csr(2'd3, 11'h7ff);
      write_csr(CSR_FILTER_MODE, CSR_DATA_BITS'(MODE_EVEN));
      write_csr(CSR_FRAME_WIDTH, 11'd1);
      write_csr(CSR_FRAME_HEIGHT, 11'd1);
      send_item(8'd254, 1'b0);
      send_item(8'd0, 1'b1);
      settle();

      // size extremes, each cut short after its first stretch of items
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      write_csr(CSR_FRAME_WIDTH, 11'd1024);
      write_csr(CSR_FRAME_HEIGHT, 11'd1);
      write_csr(CSR_FILTER_MODE, CSR_DATA_BITS'(MODE_ALL));
      send_frame(1024, 1, 0, 60);
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'h7ff);
      write_csr(CSR_FRAME_HEIGHT, 11'd0);
      write_csr(CSR_FILTER_MODE, {9'h1ff, MODE_ODD});
      send_frame(1024, 1, 1, 60);
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'd1);
      write_csr(CSR_FRAME_HEIGHT, 11'd1024);
      write_csr(CSR_FILTER_MODE, CSR_DATA_BITS'(MODE_EVEN));
      // every item from the second row on has a result, so the unit backs up
      hold_request = 1'b1;
      send_frame(1, 1024, 0, 150);
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'd0);
      write_csr(CSR_FRAME_HEIGHT, 11'h7ff);
      write_csr(CSR_FILTER_MODE, 11'd3);
      send_frame(1, 1024, 0, 150);

      // random small frames, last stretch without idling
      random_base = items_sent;
      while (items_sent < random_base + 380) begin
         settle();
         if (items_sent - random_base > 300) begin
            sender_gaps = 1'b0;
            receiver_gaps = 1'b0;
         end else begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 9))
            0: w_val = 11'd0;
            1: w_val = 11'd1;
            2: w_val = 11'd2;
            default: w_val = DIM_BITS'($urandom_range(3, 12));
         endcase
         case ($urandom_range(0, 9))
            0: h_val = 11'd0;
            1: h_val = 11'd1;
            2: h_val = 11'd2;
            default: h_val = DIM_BITS'($urandom_range(3, 8));
         endcase
         w = eff_size(w_val, MAX_WIDTH);
         h = eff_size(h_val, MAX_HEIGHT);
         if ($urandom_range(0, 1) == 0) begin
            write_csr(CSR_FRAME_WIDTH, w_val);
            write_csr(CSR_FRAME_HEIGHT, h_val);
         end else begin
            write_csr(CSR_FRAME_HEIGHT, h_val);
            write_csr(CSR_FRAME_WIDTH, w_val);
         end
         if ($urandom_range(0, 3) != 0)
            write_csr(CSR_FILTER_MODE, {9'($urandom_range(0, 511)), 2'($urandom_range(0, 3))});
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * (h + 1)) : 0;
            send_frame(w, h, $urandom_range(0, 3), cut);
            // a broken frame is restarted by the next size write
            if (cut != 0) break;
            if ($urandom_range(0, 2) == 0) begin
               settle();
               write_csr(CSR_FILTER_MODE,
                         {9'($urandom_range(0, 511)), 2'($urandom_range(0, 3))});
            end
         end
      end

      settle();
      repeat (20) @(posedge clock);
      tracker.close_out();
      if (tracker.mean_faults == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
